/* rtl/core/rgbconv_pkg.sv */
// rgbconv_pkg: shared constants and types for the RGB 3x3 filter.
// No dependencies.
`timescale 1ns / 1ps
package rgbconv_pkg;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int COEF_BITS_DEF = 16;
    localparam int CFG_DATA_W    = 48;
    localparam int CFG_IDX_W     = 3;
    localparam int PIX_MAX       = 255;
    localparam int SUM_W         = 32;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIV    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_T = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_M = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 3'd5;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // capture input item
        logic shift;     // update window and line stores
        logic mac_clr;   // clear accumulator, set tap and channel
        logic mac_step;  // one multiply-accumulate tap
        logic div_start; // start divider on accumulator
        logic div_step;  // one quotient bit
        logic store_ch;  // store clamped channel
        logic next_ch;   // advance channel
        logic out_load;  // move result to output register
        logic advance;   // advance counters
    } rgbconv_cmd_t;

    typedef struct packed {
        logic emit;      // current pixel is interior
        logic tap_last;  // last MAC tap
        logic div_last;  // last divider step
        logic ch_last;   // last channel
    } rgbconv_sts_t;
endpackage

/* rtl/core/rgb_3x3_convolution_clamp.sv */
// rgb_3x3_convolution_clamp: top level of the RGB 3x3 filter.
// Depends on rgbconv_pkg, rgbconv_ctrl, rgbconv_dp.
//
// Usage: pixels enter in raster order on pix_valid/pix_ready with
// pix_red/green/blue. Filtered interior pixels leave on out_valid/out_ready
// with channel values, their row and column, and frame_last on the final
// interior pixel. Border pixels produce no item.
// Configuration: cfg_we writes cfg_data to register cfg_index
// (0 width, 1 height, 2 divisor, 3..5 coefficient rows); write when idle.
// Sequencing: a border pixel passes through idle, read and shift only. For an
// interior pixel one shared multiply-accumulate unit visits nine taps per
// channel, then a one-bit-per-cycle divider runs 32 steps per channel.
// Reset clears counters, window and control; line stores need no clearing.
// A stalled receiver holds the result in the output register; the block
// finishes the next pixel and waits until that register frees.
`timescale 1ns / 1ps
module rgb_3x3_convolution_clamp #(
    parameter int MAX_WIDTH = rgbconv_pkg::MAX_WIDTH_DEF,
    parameter int COEF_BITS = rgbconv_pkg::COEF_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [rgbconv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rgbconv_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic        pix_valid,
    output logic        pix_ready,
    input  logic [7:0]  pix_red,
    input  logic [7:0]  pix_green,
    input  logic [7:0]  pix_blue,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [15:0] out_row,
    output logic [9:0]  out_col,
    output logic        frame_last
);
    import rgbconv_pkg::*;

    rgbconv_cmd_t cmd;
    rgbconv_sts_t sts;
    logic out_free;

    rgbconv_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(pix_valid && pix_ready),
        .out_free(out_free), .sts(sts), .in_ready(pix_ready), .cmd(cmd)
    );

    rgbconv_dp #(.MAX_WIDTH(MAX_WIDTH), .COEF_BITS(COEF_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .pix_red(pix_red), .pix_green(pix_green), .pix_blue(pix_blue),
        .out_take(out_valid && out_ready), .out_free(out_free),
        .out_valid(out_valid), .out_red(out_red), .out_green(out_green),
        .out_blue(out_blue), .out_row(out_row), .out_col(out_col),
        .frame_last(frame_last)
    );
endmodule

/* rtl/core/rgbconv_ctrl.sv */
// rgbconv_ctrl: sequencer for the RGB 3x3 filter.
// Depends on rgbconv_pkg.
`timescale 1ns / 1ps
module rgbconv_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_fire,
    input  logic                      out_free,
    input  rgbconv_pkg::rgbconv_sts_t sts,
    output logic                      in_ready,
    output rgbconv_pkg::rgbconv_cmd_t cmd
);
    import rgbconv_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_READ  = 7'b0000010,
        ST_SHIFT = 7'b0000100,
        ST_MAC   = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_STORE = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                cmd.mac_clr = 1'b1;
                if (sts.emit)
                begin
                    state_next = ST_MAC;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MAC:
            begin
                cmd.mac_step = 1'b1;
                if (sts.tap_last)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.store_ch = 1'b1;
                if (sts.ch_last)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.next_ch = 1'b1;
                    state_next = ST_MAC;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.advance = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        cmd.div_start = (state_reg == ST_MAC) && sts.tap_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

/* rtl/core/rgbconv_dp.sv */
// rgbconv_dp: line stores, window, shared MAC, serial divider, output register.
// Depends on rgbconv_pkg.
`timescale 1ns / 1ps
module rgbconv_dp #(
    parameter int MAX_WIDTH = rgbconv_pkg::MAX_WIDTH_DEF,
    parameter int COEF_BITS = rgbconv_pkg::COEF_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rgbconv_pkg::rgbconv_cmd_t   cmd,
    output rgbconv_pkg::rgbconv_sts_t   sts,
    input  logic                        cfg_we,
    input  logic [rgbconv_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [rgbconv_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [7:0]                  pix_red,
    input  logic [7:0]                  pix_green,
    input  logic [7:0]                  pix_blue,
    input  logic                        out_take,
    output logic                        out_free,
    output logic                        out_valid,
    output logic [7:0]                  out_red,
    output logic [7:0]                  out_green,
    output logic [7:0]                  out_blue,
    output logic [15:0]                 out_row,
    output logic [9:0]                  out_col,
    output logic                        frame_last
);
    import rgbconv_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int PROD_W = COEF_BITS + 9;

    // configuration registers
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [15:0] div_reg;
    logic [47:0] coef_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 11'd1024;
            height_reg <= 16'd1024;
            div_reg <= 16'd1;
            coef_reg[0] <= 48'd0;
            coef_reg[1] <= 48'd65536;
            coef_reg[2] <= 48'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_WIDTH:  width_reg <= cfg_data[10:0];
                REG_HEIGHT: height_reg <= cfg_data[15:0];
                REG_DIV:    div_reg <= cfg_data[15:0];
                REG_COEF_T: coef_reg[0] <= cfg_data;
                REG_COEF_M: coef_reg[1] <= cfg_data;
                REG_COEF_B: coef_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective geometry
    logic [13:0] w_eff;
    logic [16:0] h_eff;
    logic [15:0] d_eff;
    always_comb
    begin
        w_eff = {3'd0, width_reg};
        if (width_reg < 11'd3)
        begin
            w_eff = 14'd3;
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = 14'(MAX_WIDTH);
        end
        h_eff = (height_reg < 16'd3) ? 17'd3 : {1'b0, height_reg};
        d_eff = (div_reg == 16'd0) ? 16'd1 : div_reg;
    end

    // counters
    logic [15:0] row_reg;
    logic [9:0]  col_reg;
    logic [AW-1:0] col_a;
    logic last_col, last_row;
    assign col_a = (32'(col_reg) >= MAX_WIDTH) ? '0 : AW'(col_reg);
    assign last_col = ({4'd0, col_a} + 14'd1) >= w_eff;
    assign last_row = ({1'b0, row_reg} + 17'd1) >= h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cmd.advance)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? 16'd0 : row_reg + 16'd1;
            end
            else
            begin
                col_reg <= 10'(col_a) + 10'd1;
            end
        end
    end

    // line stores: two memories, read every cycle, written on shift
    logic [23:0] top_mem [MAX_WIDTH];
    logic [23:0] mid_mem [MAX_WIDTH];
    logic [23:0] top_rd_reg, mid_rd_reg, bot_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bot_reg <= {pix_blue, pix_green, pix_red};
        end
    end

    always_ff @(posedge clk)
    begin
        top_rd_reg <= top_mem[col_a];
        if (cmd.shift)
        begin
            top_mem[col_a] <= mid_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_rd_reg <= mid_mem[col_a];
        if (cmd.shift)
        begin
            mid_mem[col_a] <= bot_reg;
        end
    end

    // window, row-major
    logic [23:0] win_reg [9];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (cmd.shift)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k*3]   <= win_reg[k*3+1];
                win_reg[k*3+1] <= win_reg[k*3+2];
            end
            win_reg[2] <= top_rd_reg;
            win_reg[5] <= mid_rd_reg;
            win_reg[8] <= bot_reg;
        end
    end

    // MAC over nine taps for one channel
    logic [3:0]  tap_reg;
    logic [1:0]  ch_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic [7:0] px;
    logic [1:0] tr, tc;
    logic signed [COEF_BITS-1:0] cf;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0] acc_sum;

    always_comb
    begin
        // split the tap into window row and column
        if (tap_reg < 4'd3)
        begin
            tr = 2'd0;
            tc = 2'(tap_reg);
        end
        else if (tap_reg < 4'd6)
        begin
            tr = 2'd1;
            tc = 2'(tap_reg - 4'd3);
        end
        else
        begin
            tr = 2'd2;
            tc = 2'(tap_reg - 4'd6);
        end
        case (ch_reg)
            2'd0:    px = win_reg[tap_reg][7:0];
            2'd1:    px = win_reg[tap_reg][15:8];
            default: px = win_reg[tap_reg][23:16];
        endcase
        cf = coef_reg[tr][tc*COEF_BITS +: COEF_BITS];
        prod = $signed({1'b0, px}) * cf;
    end
    assign sts.tap_last = (tap_reg == 4'd8);
    assign acc_sum = acc_reg + SUM_W'(prod);

    // serial restoring divider on the magnitude
    localparam int DIV_N = SUM_W;
    logic [DIV_N-1:0] quo_reg;
    logic [16:0]      rem_reg;
    logic             neg_reg;
    logic [5:0]       dcnt_reg;
    logic [16:0]      rem_sh;
    logic [16:0]      rem_sub;
    assign rem_sh = {rem_reg[15:0], quo_reg[DIV_N-1]};
    assign rem_sub = rem_sh - {1'b0, d_eff};
    assign sts.div_last = (dcnt_reg == 6'(DIV_N - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.mac_clr)
        begin
            acc_reg <= '0;
            tap_reg <= '0;
            ch_reg <= '0;
        end
        else
        begin
            if (cmd.mac_step)
            begin
                acc_reg <= acc_sum;
                tap_reg <= tap_reg + 4'd1;
            end
            if (cmd.next_ch)
            begin
                acc_reg <= '0;
                tap_reg <= '0;
                ch_reg <= ch_reg + 2'd1;
            end
        end
        if (cmd.div_start)
        begin
            neg_reg <= acc_sum < 0;
            quo_reg <= (acc_sum < 0) ? -acc_sum : acc_sum;
            rem_reg <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg + 6'd1;
            if (!rem_sub[16])
            begin
                rem_reg <= rem_sub;
                quo_reg <= {quo_reg[DIV_N-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[DIV_N-2:0], 1'b0};
            end
        end
    end
    assign sts.ch_last = (ch_reg == 2'd2);

    // clamp and collect channels
    logic [7:0] clamp;
    logic [7:0] res_reg [3];
    assign clamp = (neg_reg || quo_reg == '0) ? 8'd0
                 : (quo_reg > DIV_N'(PIX_MAX)) ? 8'd255 : quo_reg[7:0];
    always_ff @(posedge clk)
    begin
        if (cmd.store_ch)
        begin
            res_reg[ch_reg] <= clamp;
        end
    end

    assign sts.emit = (row_reg >= 16'd2) && (col_a >= AW'(2));

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid <= 1'b0;
        end
    end
    assign out_free = !out_valid || out_take;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_red <= res_reg[0];
            out_green <= res_reg[1];
            out_blue <= res_reg[2];
            out_row <= row_reg - 16'd1;
            out_col <= 10'(col_a) - 10'd1;
            frame_last <= last_col && last_row;
        end
    end
endmodule

/* rtl/core/rgbconv_chk.sv */
// rgbconv_chk: port-level checks for the RGB 3x3 filter, bound to the top.
// Depends on rgb_3x3_convolution_clamp ports only.
`timescale 1ns / 1ps
module rgbconv_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        pix_valid,
    input logic        pix_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_red,
    input logic [9:0]  out_col,
    input logic [15:0] out_row
);
    // a held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_red))
        else $error("result changed while stalled");

    // an accepted item blocks input on the following cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready |=> !pix_ready)
        else $error("input taken twice in a row");

    // interior coordinates are never zero
    a_coord: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_col != 10'd0 && out_row != 16'd0)
        else $error("border coordinate emitted");

    // a result never rises right after an accepted input
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(pix_valid && pix_ready))
        else $error("result too soon");
endmodule

bind rgb_3x3_convolution_clamp rgbconv_chk u_chk (
    .clk(clk), .rst_n(rst_n), .pix_valid(pix_valid), .pix_ready(pix_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_red(out_red),
    .out_col(out_col), .out_row(out_row)
);

/* test/rgb_3x3_convolution_clamp_tb.sv */
// rgb_3x3_convolution_clamp_tb: self-checking testbench for the RGB 3x3 filter.
// Depends on rgbconv_pkg and rgb_3x3_convolution_clamp; holds its own filter
// predictor in a small scoreboard class and drives the pixel input from tasks.
`timescale 1ns / 1ps
module rgb_3x3_convolution_clamp_tb;
    import rgbconv_pkg::*;

    localparam int LINE_DEPTH  = 1024;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 200;
    localparam int IDLE_PCT    = 31;

    typedef struct {
        bit [7:0]  red;
        bit [7:0]  green;
        bit [7:0]  blue;
        bit [15:0] row;
        bit [9:0]  col;
        bit        last;
    } filt_pixel_t;

    // filter predictor and store of expected filtered pixels
    class conv_scoreboard;
        bit [10:0] width_reg;
        bit [15:0] height_reg;
        bit [15:0] div_reg;
        bit [47:0] coef_rows [3];
        bit [23:0] line_mem [2*LINE_DEPTH];
        bit [23:0] window [9];
        int unsigned row_cnt;
        int unsigned col_cnt;
        filt_pixel_t expected_q [$];
        int errors;
        int checked;
        int frames;

        function new();
            width_reg    = 11'd1024;
            height_reg   = 16'd1024;
            div_reg      = 16'd1;
            coef_rows[0] = 48'd0;
            coef_rows[1] = 48'd65536;
            coef_rows[2] = 48'd0;
            foreach (line_mem[i]) line_mem[i] = '0;
            foreach (window[i]) window[i] = '0;
            row_cnt = 0;
            col_cnt = 0;
            errors  = 0;
            checked = 0;
            frames  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_WIDTH:  width_reg    = data[10:0];
                REG_HEIGHT: height_reg   = data[15:0];
                REG_DIV:    div_reg      = data[15:0];
                REG_COEF_T: coef_rows[0] = data;
                REG_COEF_M: coef_rows[1] = data;
                REG_COEF_B: coef_rows[2] = data;
                default: ;
            endcase
        endfunction

        // weighted sum of one channel, signed division, clamp to 0..255
        function bit [7:0] filter(int shift, longint dv);
            longint acc;
            longint tap;
            acc = 0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                begin
                    tap = longint'($signed(coef_rows[r][16*c +: 16]));
                    acc += longint'((window[r*3+c] >> shift) & 24'hFF) * tap;
                end
            acc = acc / dv;
            if (acc < 0) acc = 0;
            if (acc > PIX_MAX) acc = PIX_MAX;
            return acc[7:0];
        endfunction

        function void note_pixel(bit [7:0] red, bit [7:0] green, bit [7:0] blue);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            longint dv;
            bit [23:0] bot;
            bit [23:0] top;
            bit [23:0] mid;
            bit last_col;
            bit last_row;
            filt_pixel_t res;
            w  = width_reg < 3 ? 3 : (width_reg > LINE_DEPTH ? LINE_DEPTH : width_reg);
            h  = height_reg < 3 ? 3 : height_reg;
            dv = div_reg == 0 ? 1 : div_reg;
            c  = col_cnt >= LINE_DEPTH ? 0 : col_cnt;
            r  = row_cnt;
            bot = {blue, green, red};
            top = line_mem[c];
            mid = line_mem[LINE_DEPTH + c];
            line_mem[c] = mid;
            line_mem[LINE_DEPTH + c] = bot;
            // shift window one column left, new column on the right
            for (int k = 0; k < 3; k++)
            begin
                window[k*3]   = window[k*3+1];
                window[k*3+1] = window[k*3+2];
            end
            window[2] = top;
            window[5] = mid;
            window[8] = bot;
            last_col = c + 1 >= w;
            last_row = r + 1 >= h;
            if (r >= 2 && c >= 2)
            begin
                res.red   = filter(0, dv);
                res.green = filter(8, dv);
                res.blue  = filter(16, dv);
                res.row   = 16'(r - 1);
                res.col   = 10'(c - 1);
                res.last  = last_col && last_row;
                expected_q.push_back(res);
            end
            if (last_col)
            begin
                col_cnt = 0;
                if (last_row) frames++;
                row_cnt = last_row ? 0 : ((r + 1) & 16'hFFFF);
            end
            else
                col_cnt = c + 1;
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_result(filt_pixel_t got);
            filt_pixel_t exp_px;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected item row %0d col %0d", got.row, got.col));
                return;
            end
            exp_px = expected_q.pop_front();
            checked++;
            if (got.red != exp_px.red)
                report($sformatf("red %0d, want %0d", got.red, exp_px.red));
            if (got.green != exp_px.green)
                report($sformatf("green %0d, want %0d", got.green, exp_px.green));
            if (got.blue != exp_px.blue)
                report($sformatf("blue %0d, want %0d", got.blue, exp_px.blue));
            if (got.row != exp_px.row)
                report($sformatf("row %0d, want %0d", got.row, exp_px.row));
            if (got.col != exp_px.col)
                report($sformatf("col %0d, want %0d", got.col, exp_px.col));
            if (got.last != exp_px.last)
                report($sformatf("frame_last %0d, want %0d", got.last, exp_px.last));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                 pix_valid;
    logic                 pix_ready;
    logic [7:0]           pix_red;
    logic [7:0]           pix_green;
    logic [7:0]           pix_blue;
    logic                 out_valid;
    logic                 out_ready;
    logic [7:0]           out_red;
    logic [7:0]           out_green;
    logic [7:0]           out_blue;
    logic [15:0]          out_row;
    logic [9:0]           out_col;
    logic                 frame_last;

    conv_scoreboard sb;
    int  cycles;
    int  sent;
    int  tx_idle;
    int  rx_idle;
    bit  hold_req;
    int  hold_cnt;

    rgb_3x3_convolution_clamp uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pix_valid(pix_valid), .pix_ready(pix_ready),
        .pix_red(pix_red), .pix_green(pix_green), .pix_blue(pix_blue),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
        .out_row(out_row), .out_col(out_col), .frame_last(frame_last)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d items outstanding",
                     cycles, sb.expected_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random back-pressure, long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_cnt = 3000;
            hold_req = 1'b0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_ready = 1'b0;
        end
        else
            out_ready = ($urandom_range(0, 99) >= rx_idle);
    end

    // check each accepted result
    always @(posedge clk)
    begin
        filt_pixel_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.red   = out_red;
            got.green = out_green;
            got.blue  = out_blue;
            got.row   = out_row;
            got.col   = out_col;
            got.last  = frame_last;
            sb.check_result(got);
        end
    end

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // hold until every expected item has arrived, then let the pipeline drain
    task automatic wait_idle();
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_pixel(input bit [7:0] red, input bit [7:0] green, input bit [7:0] blue);
        while ($urandom_range(0, 99) < tx_idle) @(negedge clk);
        pix_valid = 1'b1;
        pix_red   = red;
        pix_green = green;
        pix_blue  = blue;
        do @(posedge clk); while (!pix_ready);
        sb.note_pixel(red, green, blue);
        sent++;
        @(negedge clk);
        pix_valid = 1'b0;
    endtask

    function automatic bit [7:0] rand_sample(int mode);
        case (mode)
            0: return 8'($urandom_range(0, 255));
            1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(0, 40));
        endcase
    endfunction

    // stream n pixels; mode picks the sample spread
    task automatic send_pixels(input int n, input int mode);
        for (int i = 0; i < n; i++)
            send_pixel(rand_sample(mode), rand_sample(mode), rand_sample(mode));
    endtask

    function automatic logic [47:0] rand_coefs(int mode);
        logic [47:0] v;
        for (int c = 0; c < 3; c++)
            case (mode)
                0: v[16*c +: 16] = 16'($urandom);
                1: v[16*c +: 16] = 16'($signed($urandom_range(0, 8)) - 16'sd2);
                default: v[16*c +: 16] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            endcase
        return v;
    endfunction

    task automatic set_frame(input int w, input int h);
        set_reg(REG_WIDTH, CFG_DATA_W'(w));
        set_reg(REG_HEIGHT, CFG_DATA_W'(h));
    endtask

    initial
    begin
        int w;
        int h;
        int cmode;
        sb        = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        pix_valid = 1'b0;
        pix_red   = '0;
        pix_green = '0;
        pix_blue  = '0;
        out_ready = 1'b0;
        tx_idle   = IDLE_PCT;
        rx_idle   = IDLE_PCT;
        hold_req  = 1'b0;
        hold_cnt  = 0;
        cycles    = 0;
        sent      = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // identity filter, one 3x3 frame of extreme samples
        set_frame(3, 3);
        send_pixel(8'hFF, 8'h00, 8'hFF);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'h80, 8'h01);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'hFF, 8'h00, 8'hFF);
        wait_idle();

        // out-of-range width and height, zero divisor, most negative taps
        set_frame(0, 0);
        set_reg(REG_DIV, 48'd0);
        set_reg(REG_COEF_T, 48'h8000_8000_8000);
        set_reg(REG_COEF_M, 48'h8000_8000_8000);
        set_reg(REG_COEF_B, 48'h8000_8000_8000);
        send_pixels(9, 1);
        wait_idle();

        // most positive taps, largest divisor
        set_reg(REG_DIV, 48'hFFFF);
        set_reg(REG_COEF_T, 48'h7FFF_7FFF_7FFF);
        set_reg(REG_COEF_M, 48'h7FFF_7FFF_7FFF);
        set_reg(REG_COEF_B, 48'h7FFF_7FFF_7FFF);
        send_pixels(9, 1);
        wait_idle();

        // tallest frame cut short: shrink height mid-frame
        set_reg(REG_DIV, 48'd7);
        set_reg(REG_COEF_M, rand_coefs(1));
        set_frame(5, 16'hFFFF);
        send_pixels(20, 0);
        wait_idle();
        set_reg(REG_HEIGHT, 48'd3);
        send_pixels(5, 0);
        wait_idle();

        // width beyond the line store acts as the full store; part of a row
        set_frame(11'h7FF, 3);
        send_pixels(20, 0);
        wait_idle();

        // shrink width mid-row, finish that row and eleven more with no
        // idling while the receiver holds off so input stalls
        tx_idle = 0;
        rx_idle = 0;
        set_frame(24, 12);
        set_reg(REG_DIV, 48'd1);
        set_reg(REG_COEF_T, rand_coefs(1));
        set_reg(REG_COEF_M, rand_coefs(1));
        set_reg(REG_COEF_B, rand_coefs(1));
        hold_req = 1'b1;
        send_pixels(4 + 11 * 24, 0);
        wait_idle();
        tx_idle = IDLE_PCT;
        rx_idle = IDLE_PCT;

        // random small frames with random filters
        while (sent < 1000)
        begin
            w = $urandom_range(0, 9) == 0 ? $urandom_range(0, 40) : $urandom_range(3, 10);
            h = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 6);
            cmode = $urandom_range(0, 3) == 0 ? 0 : ($urandom_range(0, 7) == 0 ? 2 : 1);
            set_frame(w, h);
            set_reg(REG_DIV, CFG_DATA_W'($urandom_range(0, 5) == 0 ? 16'($urandom)
                                                                   : $urandom_range(0, 6)));
            set_reg(REG_COEF_T, rand_coefs(cmode));
            set_reg(REG_COEF_M, rand_coefs(cmode));
            set_reg(REG_COEF_B, rand_coefs(cmode));
            if (w < 3) w = 3;
            if (w > LINE_DEPTH) w = LINE_DEPTH;
            if (h < 3) h = 3;
            send_pixels(w * h, $urandom_range(0, 2));
            wait_idle();
        end

        $display("pixels sent %0d, filtered pixels checked %0d, frames %0d",
                 sent, sb.checked, sb.frames);
        $display("covered clamp extremes, size and divisor wrap, stalls and hold-off");
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
